### rtl/midi_voice_allocator_defines.svh
`ifndef MIDI_VOICE_ALLOCATOR_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle check
`define MVA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle check
`define MVA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mva_pkg.sv
`default_nettype none
package mva_pkg;

  localparam logic [3:0] MSG_NOTE_OFF      = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON       = 4'h9;
  localparam logic [3:0] MSG_CTRL          = 4'hB;
  localparam logic [6:0] CC_ALL_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'd123;
  localparam logic [7:0] FREE_NOTE         = 8'hFF;

  typedef enum logic [1:0] {
    OP_OTHER,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_ALL_OFF
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MATCH,
    ST_AGE,
    ST_ALLOFF,
    ST_COMMIT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### rtl/mva_msg_if.sv
`default_nettype none
interface mva_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [7:0] data_one;
  logic [7:0] data_two;

  modport source (output valid, output status_byte, output data_one, output data_two,
                  input ready);
  modport sink   (input valid, input status_byte, input data_one, input data_two,
                  output ready);
endinterface
`default_nettype wire

### rtl/mva_res_if.sv
`default_nettype none
interface mva_res_if;
  logic       valid;
  logic       ready;
  logic       assign_valid;
  logic [2:0] assign_voice;
  logic [6:0] assign_note;
  logic       reused;
  logic       stolen;
  logic [7:0] kill_mask;
  logic       release_valid;
  logic [2:0] release_voice;
  logic       fresh_onset;
  logic       begin_release;
  logic [3:0] held_count;

  modport source (output valid, output assign_valid, output assign_voice, output assign_note,
                  output reused, output stolen, output kill_mask, output release_valid,
                  output release_voice, output fresh_onset, output begin_release,
                  output held_count, input ready);
  modport sink   (input valid, input assign_valid, input assign_voice, input assign_note,
                  input reused, input stolen, input kill_mask, input release_valid,
                  input release_voice, input fresh_onset, input begin_release,
                  input held_count, output ready);
endinterface
`default_nettype wire

### rtl/midi_voice_allocator.sv
// MIDI voice allocator with oldest-voice stealing.
// Channel msg (sink): one MIDI channel message per beat - status byte and two data
// bytes. Channel res (source): one result beat per message - voice assignment, kill
// mask, release voice, onset/release events and the held note count.
// One message is handled at a time; msg.ready is high only while the block is idle.
// After accept the message is decoded. Messages that need no scan go straight to
// the result; a note-off or all-notes-off may first walk the voice table, a note-on
// that finds a voice walks it and then commits, and a note-on that has to steal
// walks it a second time for the age search before committing. The next message
// is taken the cycle after the result is loaded. The walk is done by a single
// compare unit stepping through the voice table one entry per cycle: first the
// note/channel match and free search, then the age search for the oldest voice.
// The result sits in an output register; a new message is accepted while it waits.
// If res.ready is low when the next result is due, the block holds in its final
// state until the pending beat is taken.
// Reset (synchronous, active high) frees every voice, clears ages, the age counter,
// the held count, the pending release and MIDI mode, and drops res.valid.
`default_nettype none
`include "midi_voice_allocator_defines.svh"
module midi_voice_allocator
  import mva_pkg::*;
#(
  parameter int VOICES = 8
) (
  input  wire        clk,
  input  wire        rst,
  mva_msg_if.sink    msg,
  mva_res_if.source  res
);

  localparam int VW = $clog2(VOICES);
  localparam int IW = (VW > 3) ? VW : 3;
  localparam int KW = (VOICES > 8) ? VOICES : 8;
  localparam int CW = $clog2(VOICES + 1);
  localparam int HW = (CW > 4) ? CW : 4;

  state_t state, state_next;
  op_t    op, op_in;

  logic [7:0]    voice_note    [VOICES];
  logic [3:0]    voice_channel [VOICES];
  logic [31:0]   voice_age     [VOICES];
  logic [31:0]   age_counter;
  logic [HW-1:0] held;
  logic          pend_valid;
  logic [VW-1:0] pend_idx;
  logic          midi_mode;

  logic [3:0]    chan;
  logic [6:0]    note;
  logic [VW-1:0] idx;
  logic [VW-1:0] sel;
  logic          have_free;
  logic [31:0]   best_age;
  logic          a_valid;
  logic          existing;
  logic          stolen_w;
  logic [KW-1:0] kill;
  logic          r_valid;
  logic [VW-1:0] r_voice;
  logic          fresh;
  logic          begin_rel;

  logic          accept;
  logic          hit;
  logic          this_free;
  logic          last;
  logic          emit_go;
  logic [HW-1:0] held_dec;
  logic [IW-1:0] sel_ext;
  logic [IW-1:0] rvoice_ext;
  logic [3:0]    in_type;
  logic [6:0]    in_note;
  logic [6:0]    in_vel;
  logic          rel_killed;

  assign msg.ready  = (state == ST_IDLE);
  assign accept     = msg.valid && msg.ready;
  assign in_type    = msg.status_byte[7:4];
  assign in_note    = msg.data_one[6:0];
  assign in_vel     = msg.data_two[6:0];
  assign hit        = (voice_note[idx] == {1'b0, note}) && (voice_channel[idx] == chan);
  assign this_free  = (voice_note[idx] == FREE_NOTE);
  assign last       = (idx == VW'(VOICES - 1));
  assign emit_go    = !res.valid || res.ready;
  assign held_dec   = (held != '0) ? held - 1'b1 : '0;
  assign sel_ext    = IW'(sel);
  assign rvoice_ext = IW'(r_voice);
  assign rel_killed = res.kill_mask[res.release_voice];

  always_comb begin
    if (in_type == MSG_NOTE_ON && in_vel != '0) begin
      op_in = OP_NOTE_ON;
    end else if (in_type == MSG_NOTE_OFF || in_type == MSG_NOTE_ON) begin
      op_in = OP_NOTE_OFF;
    end else if (in_type == MSG_CTRL &&
                 (in_note == CC_ALL_SOUND_OFF || in_note == CC_ALL_NOTES_OFF)) begin
      op_in = OP_ALL_OFF;
    end else begin
      op_in = OP_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (msg.valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (op)
          OP_NOTE_ON:  state_next = ST_MATCH;
          OP_NOTE_OFF: state_next = midi_mode ? ST_MATCH : ST_EMIT;
          OP_ALL_OFF:  state_next = (midi_mode && held != '0) ? ST_ALLOFF : ST_EMIT;
          default:     state_next = ST_EMIT;
        endcase
      end
      ST_MATCH: begin
        if (op == OP_NOTE_ON) begin
          if (hit) begin
            state_next = ST_COMMIT;
          end else if (last) begin
            state_next = (have_free || this_free) ? ST_COMMIT : ST_AGE;
          end
        end else if (hit || last) begin
          state_next = ST_EMIT;
        end
      end
      ST_AGE: begin
        if (last) state_next = ST_COMMIT;
      end
      ST_ALLOFF: begin
        if (last) state_next = ST_EMIT;
      end
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        voice_note[v]    <= FREE_NOTE;
        voice_channel[v] <= '0;
        voice_age[v]     <= '0;
      end
      age_counter <= '0;
      held        <= '0;
      pend_valid  <= 1'b0;
      pend_idx    <= '0;
      midi_mode   <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != ST_EMIT) res.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op        <= op_in;
            chan      <= msg.status_byte[3:0];
            note      <= in_note;
            sel       <= '0;
            idx       <= '0;
            have_free <= 1'b0;
            a_valid   <= 1'b0;
            existing  <= 1'b0;
            stolen_w  <= 1'b0;
            kill      <= '0;
            r_valid   <= 1'b0;
            r_voice   <= '0;
            fresh     <= 1'b0;
            begin_rel <= 1'b0;
          end
        end
        ST_DECODE: begin
          case (op)
            OP_NOTE_ON: begin
              if (!midi_mode) begin
                midi_mode <= 1'b1;
                for (int v = 0; v < VOICES; v++) voice_note[v] <= FREE_NOTE;
              end
              fresh <= (held == '0);
              kill  <= (!midi_mode ? KW'({VOICES{1'b1}}) : '0) |
                       ((held == '0 && pend_valid) ? (KW'(1) << pend_idx) : '0);
              if (held == '0) pend_valid <= 1'b0;
            end
            OP_ALL_OFF: begin
              if (midi_mode && held != '0) begin
                pend_valid <= 1'b0;
                pend_idx   <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_MATCH: begin
          if (op == OP_NOTE_ON) begin
            if (hit) begin
              sel      <= idx;
              existing <= 1'b1;
            end else begin
              if (!have_free && this_free) begin
                sel       <= idx;
                have_free <= 1'b1;
              end
              if (last && !(have_free || this_free)) begin
                sel      <= '0;
                best_age <= voice_age[0];
                stolen_w <= 1'b1;
                idx      <= VW'(1);
              end else if (!last) begin
                idx <= idx + 1'b1;
              end
            end
          end else begin
            if (hit) begin
              voice_note[idx] <= FREE_NOTE;
              held            <= held_dec;
              if (held_dec != '0) begin
                kill <= kill | (KW'(1) << idx);
              end else begin
                pend_valid <= 1'b1;
                pend_idx   <= idx;
                r_valid    <= 1'b1;
                r_voice    <= idx;
                begin_rel  <= 1'b1;
              end
            end else if (!last) begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_AGE: begin
          if (voice_age[idx] < best_age) begin
            sel      <= idx;
            best_age <= voice_age[idx];
          end
          if (!last) idx <= idx + 1'b1;
        end
        ST_ALLOFF: begin
          voice_note[idx] <= FREE_NOTE;
          if (!this_free && !pend_valid) begin
            pend_valid <= 1'b1;
            pend_idx   <= idx;
          end else begin
            kill <= kill | (KW'(1) << idx);
          end
          if (last) begin
            held      <= '0;
            begin_rel <= 1'b1;
            r_valid   <= pend_valid || !this_free;
            r_voice   <= pend_valid ? pend_idx : (!this_free ? idx : '0);
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_COMMIT: begin
          voice_note[sel]    <= {1'b0, note};
          voice_channel[sel] <= chan;
          voice_age[sel]     <= age_counter + 1'b1;
          age_counter        <= age_counter + 1'b1;
          if (!existing && held < HW'(VOICES)) held <= held + 1'b1;
          a_valid <= 1'b1;
        end
        ST_EMIT: begin
          if (emit_go) begin
            res.valid         <= 1'b1;
            res.assign_valid  <= a_valid;
            res.assign_voice  <= a_valid ? sel_ext[2:0] : 3'd0;
            res.assign_note   <= a_valid ? note : 7'd0;
            res.reused        <= a_valid && existing;
            res.stolen        <= a_valid && stolen_w;
            res.kill_mask     <= kill[7:0];
            res.release_valid <= r_valid;
            res.release_voice <= rvoice_ext[2:0];
            res.fresh_onset   <= fresh;
            res.begin_release <= begin_rel;
            res.held_count    <= held[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  `MVA_CHECK(a_held_bound, 1'b1, held <= HW'(VOICES), "held count above voice count")
  `MVA_CHECK(a_steal_not_reuse, res.valid, !(res.stolen && res.reused), "stolen and reused")
  `MVA_CHECK(a_release_alive, res.valid && res.release_valid, !rel_killed, "release voice killed")
  `MVA_CHECK_NEXT(a_accept_decode, accept, state == ST_DECODE, "accept did not start decode")

endmodule
`default_nettype wire
